FILE: hdl/nlp_pkg.sv
// shared types and constants for the nal length-prefix to start-code converter
`default_nettype none
package nlp_pkg;

  localparam logic [2:0] SIZE_MIN   = 3'd1;
  localparam logic [2:0] SIZE_MAX   = 3'd4;
  localparam logic [2:0] SIZE_RESET = 3'd4;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // index of the last item of a group, for a three- and a four-byte start code
  localparam logic [1:0] SC3_LAST = 2'd2;
  localparam logic [1:0] SC4_LAST = 2'd3;

  // the result items caused by one input byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt;   // index of the final item
    logic            last;  // final item closes the sample
    logic            err;   // single error item
  } grp_t;

endpackage
`default_nettype wire

FILE: hdl/nlp_emit.sv
// output serializer: holds one result group and hands it out item by item
`default_nettype none
module nlp_emit
  import nlp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire grp_t       grp_in,
  output logic            can_load,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            frame_error
);

  grp_t       grp;
  logic [1:0] idx;
  logic       busy;
  logic       at_end;

  assign at_end   = (idx == grp.cnt);
  assign can_load = !busy || (out_ready && at_end);

  assign out_valid   = busy;
  assign out_byte    = grp.bytes[idx];
  assign out_last    = grp.last && at_end;
  assign frame_error = grp.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && out_ready) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/nal_length_prefix_to_start_code.sv
// top level of the nal length-prefix to start-code converter
`default_nettype none
// Converts length-prefixed H.264 samples into an Annex B byte stream. Bytes
// of a sample arrive one per transfer, frame_end marking the last. Each NAL
// prefix of length_size bytes (big-endian) is absorbed; its final byte yields
// a start code, 00 00 00 01 for the first NAL of a sample and 00 00 01 after,
// then the payload bytes pass straight through. A sample cut short inside a
// prefix or payload ends in one error transfer (out_byte 0, out_last and
// frame_error high). Rate: one input byte per cycle and one output byte per
// cycle while out_ready is high; the byte that completes a prefix occupies
// the output serializer with its three or four start-code bytes, and
// in_ready stays low until the last of them leaves. Output is registered:
// the first output byte of an input transfer appears in the cycle after it.
// Write length_size only while idle; 0 acts as 1 and 5 to 7 act as 4.
module nal_length_prefix_to_start_code
  import nlp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       length_size_we,
  input  wire logic [2:0] length_size,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       frame_end,
  // output channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            frame_error
);

  // configuration register
  logic [2:0] size_cfg;
  logic [2:0] eff_size;

  // parser state
  logic                   in_prefix;
  logic [2:0]             prefix_count;
  logic [LENGTH_BITS-1:0] length_accum;
  logic [LENGTH_BITS-1:0] payload_left;
  logic                   first_unit;

  logic                   in_prefix_next;
  logic [2:0]             prefix_count_next;
  logic [LENGTH_BITS-1:0] length_accum_next;
  logic [LENGTH_BITS-1:0] payload_left_next;
  logic                   first_unit_next;

  logic                   in_xfer;
  logic [LENGTH_BITS+7:0] accum_wide;
  logic [LENGTH_BITS-1:0] accum_shift;
  logic [2:0]             count_inc;
  logic                   has_result;
  logic                   clean;
  grp_t                   grp;

  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= SIZE_RESET;
    end else if (length_size_we) begin
      size_cfg <= length_size;
    end
  end

  // out-of-range sizes clamp to the nearest legal one
  always_comb begin
    if (size_cfg < SIZE_MIN) begin
      eff_size = SIZE_MIN;
    end else if (size_cfg > SIZE_MAX) begin
      eff_size = SIZE_MAX;
    end else begin
      eff_size = size_cfg;
    end
  end

  // prefix value kept modulo 2^LENGTH_BITS
  assign accum_wide  = {length_accum, in_byte};
  assign accum_shift = accum_wide[LENGTH_BITS-1:0];
  assign count_inc   = prefix_count + 3'd1;

  // one step of the parser plus the result group it causes
  always_comb begin
    in_prefix_next    = in_prefix;
    prefix_count_next = prefix_count;
    length_accum_next = length_accum;
    payload_left_next = payload_left;
    first_unit_next   = first_unit;
    has_result        = 1'b0;
    grp.bytes         = '0;
    grp.cnt           = 2'd0;
    grp.last          = 1'b0;
    grp.err           = 1'b0;

    if (in_prefix) begin
      length_accum_next = accum_shift;
      prefix_count_next = count_inc;
      if (count_inc >= eff_size) begin
        // prefix complete: start code, then payload unless the length is zero
        has_result = 1'b1;
        if (first_unit) begin
          grp.cnt = SC4_LAST;
          grp.bytes[SC4_LAST] = SC_ONE;
        end else begin
          grp.cnt = SC3_LAST;
          grp.bytes[SC3_LAST] = SC_ONE;
        end
        first_unit_next   = 1'b0;
        payload_left_next = accum_shift;
        length_accum_next = '0;
        prefix_count_next = 3'd0;
        in_prefix_next    = (accum_shift == '0);
      end
    end else begin
      has_result        = 1'b1;
      grp.bytes[0]      = in_byte;
      payload_left_next = payload_left - LENGTH_BITS'(1);
      if (payload_left_next == '0) begin
        in_prefix_next = 1'b1;
      end
    end

    if (frame_end) begin
      clean = in_prefix_next && (prefix_count_next == 3'd0) && has_result;
      if (clean) begin
        grp.last = 1'b1;
      end else begin
        // cut-short sample: everything replaced by one error item
        has_result = 1'b1;
        grp.bytes  = '0;
        grp.cnt    = 2'd0;
        grp.last   = 1'b1;
        grp.err    = 1'b1;
      end
      in_prefix_next    = 1'b1;
      prefix_count_next = 3'd0;
      length_accum_next = '0;
      payload_left_next = '0;
      first_unit_next   = 1'b1;
    end else begin
      clean = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_prefix    <= 1'b1;
      prefix_count <= 3'd0;
      length_accum <= '0;
      payload_left <= '0;
      first_unit   <= 1'b1;
    end else if (in_xfer) begin
      in_prefix    <= in_prefix_next;
      prefix_count <= prefix_count_next;
      length_accum <= length_accum_next;
      payload_left <= payload_left_next;
      first_unit   <= first_unit_next;
    end
  end

  // result register and serializer; it takes a new group on the cycle the
  // previous one hands out its final item
  nlp_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (in_xfer && has_result),
    .grp_in      (grp),
    .can_load    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .frame_error (frame_error)
  );

`ifndef ASSERT_OFF
  // an error transfer is always the closing, zeroed item of a sample
  a_err_closes : assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_error) |-> (out_last && out_byte == 8'h00))
    else $error("error transfer not closing or not zero");

  // a sample end leaves the parser ready for a fresh sample
  a_restart : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && frame_end) |=> (in_prefix && first_unit && prefix_count == 3'd0))
    else $error("parser not restarted after sample end");

  // an empty serializer never stalls the input
  a_no_stall : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output empty");

  // inside a payload the byte count never sits at zero
  a_payload_live : assert property (@(posedge clk) disable iff (rst)
    !in_prefix |-> (payload_left != '0))
    else $error("payload state with zero bytes left");
`endif

endmodule
`default_nettype wire
